// ----- hdl/kar_pkg.sv -----
// Shared types and constants for the key auto-repeat generator.
`timescale 1ns / 1ps

package kar_pkg;

    // Key map width and the ceiling on walked keys set by it
    localparam int KEY_MAP_W    = 16;
    localparam int KEY_LIMIT    = 16;
    localparam int KEY_IDX_W    = 4;
    localparam int TIME_W       = 32;
    localparam int NUM_KEYS_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTERED_KEYS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd2;

    localparam logic [KEY_MAP_W-1:0] REG_KEYS_RST  = '0;
    localparam logic [TIME_W-1:0]    FIRST_DLY_RST = 32'd400;
    localparam logic [TIME_W-1:0]    REPEAT_RST    = 32'd200;
    localparam logic [TIME_W-1:0]    DUE_IDLE      = 32'hFFFF_FFFF;

    // Queue depths (powers of two)
    localparam int SCANQ_DEPTH = 2;
    localparam int EVQ_DEPTH   = 2;

    typedef struct packed {
        logic [KEY_MAP_W-1:0] keys_down;
        logic [TIME_W-1:0]    now_ms;
    } t_scan;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_index;
        logic                 is_press;
        logic                 last;
    } t_event;

endpackage

// ----- hdl/kar_front.sv -----
// Scan intake: drop unfocused scans and queue focused ones for the walker.
`timescale 1ns / 1ps

module kar_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_focused,
    input  logic [kar_pkg::KEY_MAP_W-1:0]  i_keys_down,
    input  logic [kar_pkg::TIME_W-1:0]     i_now_ms,
    output logic                           o_full,
    output logic                           o_scan_valid,
    output kar_pkg::t_scan                 o_scan,
    input  logic                           i_scan_take
);
    import kar_pkg::*;

    localparam int PW = (SCANQ_DEPTH > 1) ? $clog2(SCANQ_DEPTH) : 1;
    localparam int CW = $clog2(SCANQ_DEPTH + 1);

    t_scan          r_q [SCANQ_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           wr, rd;

    assign o_full       = (r_cnt == CW'(SCANQ_DEPTH));
    assign o_scan_valid = (r_cnt != '0);
    assign o_scan       = r_q[r_rp];

    // unfocused scans are accepted and dropped here
    assign wr = i_push && !o_full && i_focused;
    assign rd = i_scan_take && o_scan_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= '{keys_down: i_keys_down, now_ms: i_now_ms};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= PW'(r_wp + 1'b1);
            if (rd) r_rp <= PW'(r_rp + 1'b1);
            case ({wr, rd})
                2'b10:   r_cnt <= CW'(r_cnt + 1'b1);
                2'b01:   r_cnt <= CW'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/kar_walk.sv -----
// Key walker: per-key level and due-time state, one key per cycle while the event queue has room, event staging.
`timescale 1ns / 1ps

module kar_walk #(
    parameter int NUM_KEYS = kar_pkg::NUM_KEYS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_scan_valid,
    input  kar_pkg::t_scan                 i_scan,
    output logic                           o_scan_take,
    input  logic [kar_pkg::KEY_MAP_W-1:0]  i_reg_keys,
    input  logic [kar_pkg::TIME_W-1:0]     i_first_delay,
    input  logic [kar_pkg::TIME_W-1:0]     i_repeat_interval,
    input  logic                           i_evq_full,
    output logic                           o_ev_push,
    output kar_pkg::t_event                o_ev
);
    import kar_pkg::*;

    // keys above the map width can never be registered
    localparam int WALK = (NUM_KEYS < KEY_LIMIT) ? NUM_KEYS : KEY_LIMIT;
    localparam int KW   = (WALK > 1) ? $clog2(WALK) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_walk_state;

    t_walk_state           r_state;
    logic [KW-1:0]         r_key;
    logic [KEY_MAP_W-1:0]  r_down;
    logic [TIME_W-1:0]     r_now;
    logic [WALK-1:0]       r_prev;
    logic [TIME_W-1:0]     r_due [WALK];
    logic                  r_pend_valid;
    logic [KEY_IDX_W-1:0]  r_pend_idx;
    logic                  r_pend_press;

    logic                  lvl, regd, chg, fire, emit, step, last_key;
    logic [TIME_W-1:0]     due_cur, due_fire;

    always_comb begin
        lvl      = r_down[r_key];
        regd     = i_reg_keys[r_key];
        chg      = (lvl != r_prev[r_key]);
        due_cur  = chg ? (lvl ? r_now : DUE_IDLE) : r_due[r_key];
        // plain unsigned compare; equal means first emission
        fire     = lvl && (due_cur <= r_now);
        due_fire = r_now + ((due_cur == r_now) ? i_first_delay : i_repeat_interval);
        emit     = regd && (fire || !lvl);
        step     = (r_state == S_WALK) && !i_evq_full;
        last_key = (r_key == KW'(WALK - 1));
    end

    assign o_scan_take = (r_state == S_IDLE) && i_scan_valid;

    // a staged event goes out once the next one is found, or at the end flagged last
    assign o_ev_push = (step && emit && r_pend_valid)
                    || ((r_state == S_FLUSH) && r_pend_valid && !i_evq_full);
    assign o_ev = '{key_index: r_pend_idx, is_press: r_pend_press,
                    last: (r_state == S_FLUSH)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            for (int k = 0; k < WALK; k++) begin
                r_due[k] <= DUE_IDLE;
            end
        end else if (step && regd) begin
            r_prev[r_key] <= lvl;
            r_due[r_key]  <= fire ? due_fire : due_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_scan_take) begin
            r_down <= i_scan.keys_down;
            r_now  <= i_scan.now_ms;
        end
        if (step && emit) begin
            r_pend_idx   <= KEY_IDX_W'(r_key);
            r_pend_press <= lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_scan_take) begin
                        r_key   <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (step) begin
                        if (emit) r_pend_valid <= 1'b1;
                        if (last_key) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_key <= KW'(r_key + 1'b1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (!i_evq_full) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/kar_evq.sv -----
// Event queue: holds finished events until the consumer pops them.
`timescale 1ns / 1ps

module kar_evq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ev_push,
    input  kar_pkg::t_event  i_ev,
    output logic             o_evq_full,
    output logic             o_empty,
    output kar_pkg::t_event  o_ev,
    input  logic             i_pop
);
    import kar_pkg::*;

    localparam int PW = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
    localparam int CW = $clog2(EVQ_DEPTH + 1);

    t_event         r_q [EVQ_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           wr, rd;

    assign o_evq_full = (r_cnt == CW'(EVQ_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_ev       = r_q[r_rp];

    assign wr = i_ev_push && !o_evq_full;
    assign rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= PW'(r_wp + 1'b1);
            if (rd) r_rp <= PW'(r_rp + 1'b1);
            case ({wr, rd})
                2'b10:   r_cnt <= CW'(r_cnt + 1'b1);
                2'b01:   r_cnt <= CW'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/key_auto_repeat_generator.sv -----
// With the walker idle, a scan's first word reaches the output queue once the second emitting key is
// found, or at the flush when a single key emits. Each scan is loaded, its keys walked one key per
// cycle while the event queue has room, then flushed; the walker takes the next scan only once back in
// idle. Unfocused scans are dropped on entry. Two scans queue in front, two words behind.
// Reset (synchronous, active low): queues empty, all keys up, due times all ones,
// registered keys cleared, first delay 400 and repeat interval 200.
`timescale 1ns / 1ps

module key_auto_repeat_generator #(
    parameter int NUM_KEYS = kar_pkg::NUM_KEYS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // scan input
    input  logic                            push,
    output logic                            full,
    input  logic                            i_focused,
    input  logic [kar_pkg::KEY_MAP_W-1:0]   i_keys_down,
    input  logic [kar_pkg::TIME_W-1:0]      i_now_ms,
    // event output
    output logic                            empty,
    input  logic                            pop,
    output logic [kar_pkg::KEY_IDX_W-1:0]   o_key_index,
    output logic                            o_is_press,
    output logic                            o_last,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [kar_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kar_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import kar_pkg::*;

    logic [KEY_MAP_W-1:0] r_reg_keys;
    logic [TIME_W-1:0]    r_first_delay;
    logic [TIME_W-1:0]    r_repeat_interval;

    logic    scan_valid, scan_take, ev_push, evq_full;
    t_scan   scan;
    t_event  ev_in, ev_out;

    // Configuration registers: the user is to write them only while the block is idle, so the
    // walker reads them live; the block itself does not enforce this. An unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_keys        <= REG_KEYS_RST;
            r_first_delay     <= FIRST_DLY_RST;
            r_repeat_interval <= REPEAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REGISTERED_KEYS: r_reg_keys        <= i_cfg_data[KEY_MAP_W-1:0];
                CFG_FIRST_DELAY:     r_first_delay     <= i_cfg_data[TIME_W-1:0];
                CFG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: take scans, drop the unfocused ones, queue the rest
    kar_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_focused    (i_focused),
        .i_keys_down  (i_keys_down),
        .i_now_ms     (i_now_ms),
        .o_full       (full),
        .o_scan_valid (scan_valid),
        .o_scan       (scan),
        .i_scan_take  (scan_take)
    );

    // Back: walk the keys, update levels and due times, stage one event so
    // the final word of a scan can carry its last flag
    kar_walk #(
        .NUM_KEYS (NUM_KEYS)
    ) u_walk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_scan_valid      (scan_valid),
        .i_scan            (scan),
        .o_scan_take       (scan_take),
        .i_reg_keys        (r_reg_keys),
        .i_first_delay     (r_first_delay),
        .i_repeat_interval (r_repeat_interval),
        .i_evq_full        (evq_full),
        .o_ev_push         (ev_push),
        .o_ev              (ev_in)
    );

    // Output queue: hold finished words for the consumer
    kar_evq u_evq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_push  (ev_push),
        .i_ev       (ev_in),
        .o_evq_full (evq_full),
        .o_empty    (empty),
        .o_ev       (ev_out),
        .i_pop      (pop)
    );

    assign o_key_index = ev_out.key_index;
    assign o_is_press  = ev_out.is_press;
    assign o_last      = ev_out.last;

endmodule

// ----- hdl/kar_checker.sv -----
// Port-level checks for the key auto-repeat generator, bound to the top level.
`timescale 1ns / 1ps

module kar_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [kar_pkg::KEY_IDX_W-1:0]  o_key_index,
    input logic                           o_is_press,
    input logic                           o_last
);
    import kar_pkg::*;

    // Hold the head word until it is popped
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_key_index)
                              && $stable(o_is_press) && $stable(o_last)))
        else $error("head word changed while waiting");

    // Within one scan, words come in strictly ascending key order
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last) ##1 !empty |-> (o_key_index > $past(o_key_index)))
        else $error("key order broken within a scan");

    // Reset leaves both queues empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // The input side only fills up on a push
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

endmodule

bind key_auto_repeat_generator kar_checker u_kar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_key_index (o_key_index),
    .o_is_press  (o_is_press),
    .o_last      (o_last)
);

// ----- tb/key_auto_repeat_generator_tb.sv -----
// Self-checking testbench for the key auto-repeat generator: directed scan table, then random scans.
`timescale 1ns / 1ps

module key_auto_repeat_generator_tb;

    import kar_pkg::*;

    // Clock, reset and block ports
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    logic                  i_focused   = 1'b0;
    logic [KEY_MAP_W-1:0]  i_keys_down = '0;
    logic [TIME_W-1:0]     i_now_ms    = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [KEY_IDX_W-1:0]  o_key_index;
    logic                  o_is_press;
    logic                  o_last;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Time for every scan still queued in front of and inside the walker to pass, with margin
    localparam int SETTLE_CYCLES = 80;
    // Length of the one long receiver hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int RAND_PHASES   = 6;
    localparam int RAND_PER_PHASE = 48;

    key_auto_repeat_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_focused   (i_focused),
        .i_keys_down (i_keys_down),
        .i_now_ms    (i_now_ms),
        .empty       (empty),
        .pop         (pop),
        .o_key_index (o_key_index),
        .o_is_press  (o_is_press),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: key levels, due times and the three registers
    // ------------------------------------------------------------------
    logic [KEY_MAP_W-1:0] shadow_reg_keys;
    logic [TIME_W-1:0]    shadow_first_dly;
    logic [TIME_W-1:0]    shadow_rep_ivl;
    logic                 key_level [KEY_MAP_W];
    logic [TIME_W-1:0]    due_ms    [KEY_MAP_W];

    // Event words still to come out of the block, oldest first
    t_event pending_events [$];

    int errors        = 0;
    int scans_sent    = 0;
    int words_checked = 0;
    int hold_requests = 0;

    // Generous cap on the whole run
    initial begin
        #25_000_000;
        $display("%0t: timeout with %0d words still awaited", $time, pending_events.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Work out one focused scan: which keys press and which release.
    // The walk order is ascending, so the two masks fix the word sequence.
    function automatic void predict_scan(input logic [KEY_MAP_W-1:0] keys,
                                         input logic [TIME_W-1:0] now_v,
                                         output logic [KEY_MAP_W-1:0] press_map,
                                         output logic [KEY_MAP_W-1:0] release_map);
        int k;
        press_map   = '0;
        release_map = '0;
        // Sample levels of registered keys and stamp the edges
        for (k = 0; k < KEY_MAP_W; k++) begin
            if (shadow_reg_keys[k]) begin
                if (keys[k] != key_level[k])
                    due_ms[k] = keys[k] ? now_v : DUE_IDLE;
                key_level[k] = keys[k];
            end
        end
        // Walk and reschedule; an exact hit on now counts as the first emission
        for (k = 0; k < KEY_MAP_W; k++) begin
            if (shadow_reg_keys[k]) begin
                if (key_level[k]) begin
                    if (due_ms[k] <= now_v) begin
                        if (due_ms[k] == now_v)
                            due_ms[k] = now_v + shadow_first_dly;
                        else
                            due_ms[k] = now_v + shadow_rep_ivl;
                        press_map[k] = 1'b1;
                    end
                end else begin
                    release_map[k] = 1'b1;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef enum bit {ROW_SCAN, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [TIME_W-1:0]    cfg_data;
        logic                 focused;
        logic [KEY_MAP_W-1:0] keys;
        logic [TIME_W-1:0]    now_v;
        bit                   typed;       // expected masks given in the row
        logic [KEY_MAP_W-1:0] press_map;
        logic [KEY_MAP_W-1:0] release_map;
    } t_row;

    t_row directed_rows [$];

    // Append one row to the end of the table
    function automatic void add_row(input t_row r);
        directed_rows = {directed_rows, r};
    endfunction

    function automatic t_row scan_row(input logic f, input logic [KEY_MAP_W-1:0] keys,
                                      input logic [TIME_W-1:0] now_v, input bit typed,
                                      input logic [KEY_MAP_W-1:0] pm,
                                      input logic [KEY_MAP_W-1:0] rm);
        t_row r;
        r.kind        = ROW_SCAN;
        r.cfg_idx     = CFG_REGISTERED_KEYS;
        r.cfg_data    = '0;
        r.focused     = f;
        r.keys        = keys;
        r.now_v       = now_v;
        r.typed       = typed;
        r.press_map   = pm;
        r.release_map = rm;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [TIME_W-1:0] data);
        t_row r;
        r = scan_row(1'b0, '0, '0, 1'b0, '0, '0);
        r.kind     = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one scan, hold it until taken, then queue the words it must cause.
    // Typed rows queue the masks given in the table; the shadow still advances.
    task automatic send_scan(input logic f, input logic [KEY_MAP_W-1:0] keys,
                             input logic [TIME_W-1:0] now_v, input bit typed,
                             input logic [KEY_MAP_W-1:0] typed_pm,
                             input logic [KEY_MAP_W-1:0] typed_rm);
        logic [KEY_MAP_W-1:0] pm;
        logic [KEY_MAP_W-1:0] rm;
        logic [KEY_MAP_W-1:0] hits;
        int                   k;
        int                   last_k;
        t_event               ev;
        push        <= 1'b1;
        i_focused   <= f;
        i_keys_down <= keys;
        i_now_ms    <= now_v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        scans_sent++;
        // Unfocused scans are dropped without touching any state
        if (f) begin
            predict_scan(keys, now_v, pm, rm);
            if (typed) begin
                pm = typed_pm;
                rm = typed_rm;
            end
            hits   = pm | rm;
            last_k = -1;
            for (k = 0; k < KEY_MAP_W; k++)
                if (hits[k]) last_k = k;
            for (k = 0; k < KEY_MAP_W; k++) begin
                if (hits[k]) begin
                    ev.key_index = k[KEY_IDX_W-1:0];
                    ev.is_press  = pm[k];
                    ev.last      = (k == last_k);
                    pending_events = {pending_events, ev};
                end
            end
        end
    endtask

    // Drop push and wait until every awaited word has come, then let the walker finish
    // any scan that causes no word.
    task automatic drain_block();
        push <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register once the block is idle, and mirror it in the shadow
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        drain_block();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_REGISTERED_KEYS: shadow_reg_keys  = data[KEY_MAP_W-1:0];
            CFG_FIRST_DELAY:     shadow_first_dly = data;
            CFG_REPEAT_INTERVAL: shadow_rep_ivl   = data;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random pop with short and long stalls, calm stretches,
    // and one long hold-off counted here
    // ------------------------------------------------------------------
    t_event want;
    int     pop_stall = 0;
    int     pop_calm  = 0;
    int     hold_left = 0;
    int     hold_seen = 0;
    int     pop_roll;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            // Check the word taken at this edge against the oldest expectation
            if (pop && !empty) begin
                words_checked++;
                if (pending_events.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word: expected none, actual key %0d press %0b last %0b",
                             $time, o_key_index, o_is_press, o_last);
                end else begin
                    want = pending_events.pop_front();
                    if (o_key_index !== want.key_index) begin
                        errors++;
                        $display("%0t: key_index mismatch: expected %0d, actual %0d",
                                 $time, want.key_index, o_key_index);
                    end
                    if (o_is_press !== want.is_press) begin
                        errors++;
                        $display("%0t: is_press mismatch: expected %0b, actual %0b",
                                 $time, want.is_press, o_is_press);
                    end
                    if (o_last !== want.last) begin
                        errors++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, o_last);
                    end
                end
            end
            // Pick pop for the next edge
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (pop_calm > 0) begin
                    pop_calm--;
                end else begin
                    pop_roll = $urandom_range(0, 99);
                    if (pop_roll < 3)
                        pop_calm = 60;
                    else if (pop_roll < 8)
                        pop_stall = $urandom_range(10, 40);
                    else if (pop_roll < 35)
                        pop_stall = $urandom_range(1, 3);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int                   row;
        int                   phase;
        int                   n;
        int                   roll;
        int                   gap;
        int                   send_calm;
        int                   k;
        logic                 f;
        logic [KEY_MAP_W-1:0] keys;
        logic [TIME_W-1:0]    scan_ms;
        logic [KEY_MAP_W-1:0] r_reg;
        logic [TIME_W-1:0]    r_first;
        logic [TIME_W-1:0]    r_rep;

        // Shadow follows the reset state
        shadow_reg_keys  = REG_KEYS_RST;
        shadow_first_dly = FIRST_DLY_RST;
        shadow_rep_ivl   = REPEAT_RST;
        for (k = 0; k < KEY_MAP_W; k++) begin
            key_level[k] = 1'b0;
            due_ms[k]    = DUE_IDLE;
        end
        send_calm = 0;

        // Hold reset, then release it once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing registered after reset: no words, focused or not
        add_row(scan_row(1'b1, 16'hFFFF, 32'd0, 1'b1, 16'h0000, 16'h0000));
        add_row(scan_row(1'b0, 16'hFFFF, 32'd5, 1'b1, 16'h0000, 16'h0000));
        add_row(cfg_row(CFG_REGISTERED_KEYS, 32'h0000_FFFF));
        // All keys up: every key releases, sixteen words
        add_row(scan_row(1'b1, 16'h0000, 32'd0, 1'b1, 16'h0000, 16'hFFFF));
        // All keys go down: first emission on every key, due at now plus 400
        add_row(scan_row(1'b1, 16'hFFFF, 32'd100, 1'b1, 16'hFFFF, 16'h0000));
        // One short of the due time: silent
        add_row(scan_row(1'b1, 16'hFFFF, 32'd499, 1'b1, 16'h0000, 16'h0000));
        add_row(scan_row(1'b1, 16'hFFFF, 32'd600, 1'b0, '0, '0));
        // Unfocused scan leaves state alone
        add_row(scan_row(1'b0, 16'h0000, 32'd900, 1'b1, 16'h0000, 16'h0000));
        add_row(scan_row(1'b1, 16'h00FF, 32'd900, 1'b0, '0, '0));
        // Only the end keys registered; the rest keep their stored level
        add_row(cfg_row(CFG_REGISTERED_KEYS, 32'h0000_8001));
        add_row(scan_row(1'b1, 16'h0000, 32'd1000, 1'b0, '0, '0));
        // Extreme delays: wrap of the due time, all-ones due firing only at all-ones now
        add_row(cfg_row(CFG_FIRST_DELAY, 32'hFFFF_FFFF));
        add_row(cfg_row(CFG_REPEAT_INTERVAL, 32'h0000_0000));
        add_row(scan_row(1'b1, 16'h8001, 32'hFFFF_FFFE, 1'b0, '0, '0));
        add_row(scan_row(1'b1, 16'h8001, 32'hFFFF_FFFF, 1'b0, '0, '0));
        add_row(scan_row(1'b1, 16'h8001, 32'hFFFF_FFFF, 1'b0, '0, '0));
        add_row(scan_row(1'b1, 16'h0000, 32'd0, 1'b0, '0, '0));
        add_row(cfg_row(CFG_FIRST_DELAY, 32'h0000_0000));
        add_row(cfg_row(CFG_REPEAT_INTERVAL, 32'hFFFF_FFFF));
        // Re-register every key: the frozen levels of the middle keys come back into play
        add_row(cfg_row(CFG_REGISTERED_KEYS, 32'h0000_FFFF));
        add_row(scan_row(1'b1, 16'hAAAA, 32'd0, 1'b0, '0, '0));
        add_row(scan_row(1'b1, 16'hAAAA, 32'd0, 1'b0, '0, '0));
        add_row(scan_row(1'b1, 16'h5555, 32'd7, 1'b0, '0, '0));
        add_row(scan_row(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0, '0));
        add_row(cfg_row(CFG_REGISTERED_KEYS, 32'h0000_0000));
        add_row(scan_row(1'b1, 16'hFFFF, 32'd123, 1'b1, 16'h0000, 16'h0000));

        for (row = 0; row < directed_rows.size(); row++) begin
            if (directed_rows[row].kind == ROW_CFG)
                write_cfg(directed_rows[row].cfg_idx, directed_rows[row].cfg_data);
            else
                send_scan(directed_rows[row].focused, directed_rows[row].keys,
                          directed_rows[row].now_v, directed_rows[row].typed,
                          directed_rows[row].press_map, directed_rows[row].release_map);
        end

        // Random phases, each with its own register setting
        keys = '0;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin
                    r_reg   = 16'hFFFF;
                    r_first = $urandom_range(20, 60);
                    r_rep   = $urandom_range(5, 30);
                    scan_ms = $urandom_range(0, 1000);
                end
                1: begin
                    // Time runs through the wrap of the millisecond counter
                    r_reg   = 16'($urandom);
                    r_first = $urandom_range(10, 50);
                    r_rep   = $urandom_range(1, 20);
                    scan_ms = 32'hFFFF_FF00 + $urandom_range(0, 100);
                end
                2: begin
                    // Zero delays: every held key fires on every scan
                    r_reg   = 16'hFFFF;
                    r_first = 32'd0;
                    r_rep   = 32'd0;
                    scan_ms = $urandom;
                end
                3: begin
                    r_reg   = 16'($urandom);
                    r_first = 32'hFFFF_FFFF;
                    r_rep   = 32'hFFFF_FFFF;
                    scan_ms = $urandom;
                end
                4: begin
                    r_reg   = 16'($urandom);
                    r_first = $urandom;
                    r_rep   = $urandom;
                    scan_ms = $urandom;
                end
                default: begin
                    r_reg   = 16'($urandom);
                    r_first = $urandom_range(0, 50);
                    r_rep   = $urandom_range(1, 20);
                    scan_ms = $urandom_range(0, 100);
                end
            endcase
            write_cfg(CFG_REGISTERED_KEYS, {16'h0000, r_reg});
            write_cfg(CFG_FIRST_DELAY, r_first);
            write_cfg(CFG_REPEAT_INTERVAL, r_rep);
            // Hold the receiver off while scans keep coming, so both queues fill
            if (phase == 0)
                hold_requests++;

            for (n = 0; n < RAND_PER_PHASE; n++) begin
                // Pause the sender until every awaited word is out
                if (phase == RAND_PHASES - 1 && n == RAND_PER_PHASE / 2)
                    drain_block();
                // Mostly hold the key map and toggle a few keys; now and then a fresh map
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    repeat ($urandom_range(0, 2)) begin
                        k = $urandom_range(0, KEY_MAP_W - 1);
                        keys[k] = ~keys[k];
                    end
                end else if (roll < 85) begin
                    keys = 16'($urandom);
                end
                // Advance time, mostly in small steps
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    scan_ms = $urandom;
                else if (roll >= 20)
                    scan_ms = scan_ms + $urandom_range(1, 40);
                f = ($urandom_range(0, 9) != 0);
                send_scan(f, keys, scan_ms, 1'b0, '0, '0);

                // Gap before the next scan
                if (send_calm > 0) begin
                    send_calm--;
                    gap = 0;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3) begin
                        send_calm = 30;
                        gap = 0;
                    end else if (roll < 8) begin
                        gap = $urandom_range(10, 40);
                    end else if (roll < 33) begin
                        gap = $urandom_range(1, 3);
                    end else begin
                        gap = 0;
                    end
                end
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        // Wait out the remaining words and any trailing walker activity
        push <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d scans (directed table, then %0d random register settings).",
                 scans_sent, RAND_PHASES);
        $display("Checked %0d event words, including a long receiver hold-off and wrap of time.",
                 words_checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
